>>> design/mpe_pkg.sv
// Shared types and constants for the MessagePack value encoder.
// No dependencies; imported by every module of the block.
package mpe_pkg;

    // Kind selector carried with each input word
    typedef enum logic [3:0] {
        OP_NIL     = 4'd0,
        OP_BOOL    = 4'd1,
        OP_UINT    = 4'd2,
        OP_INT     = 4'd3,
        OP_DOUBLE  = 4'd4,
        OP_BIN     = 4'd5,
        OP_STR     = 4'd6,
        OP_ARRAY   = 4'd7,
        OP_MAP     = 4'd8,
        OP_PAYLOAD = 4'd9
    } t_op;

    // Marker bytes
    localparam logic [7:0] MK_NIL    = 8'hC0;
    localparam logic [7:0] MK_FALSE  = 8'hC2;
    localparam logic [7:0] MK_TRUE   = 8'hC3;
    localparam logic [7:0] MK_BIN8   = 8'hC4;
    localparam logic [7:0] MK_BIN16  = 8'hC5;
    localparam logic [7:0] MK_BIN32  = 8'hC6;
    localparam logic [7:0] MK_DOUBLE = 8'hCB;
    localparam logic [7:0] MK_UINT8  = 8'hCC;
    localparam logic [7:0] MK_UINT16 = 8'hCD;
    localparam logic [7:0] MK_UINT32 = 8'hCE;
    localparam logic [7:0] MK_UINT64 = 8'hCF;
    localparam logic [7:0] MK_INT8   = 8'hD0;
    localparam logic [7:0] MK_INT16  = 8'hD1;
    localparam logic [7:0] MK_INT32  = 8'hD2;
    localparam logic [7:0] MK_INT64  = 8'hD3;
    localparam logic [7:0] MK_STR8   = 8'hD9;
    localparam logic [7:0] MK_STR16  = 8'hDA;
    localparam logic [7:0] MK_STR32  = 8'hDB;
    localparam logic [7:0] MK_ARR16  = 8'hDC;
    localparam logic [7:0] MK_ARR32  = 8'hDD;
    localparam logic [7:0] MK_MAP16  = 8'hDE;
    localparam logic [7:0] MK_MAP32  = 8'hDF;
    localparam logic [2:0] FIX_STR   = 3'b101;
    localparam logic [3:0] FIX_ARRAY = 4'b1001;
    localparam logic [3:0] FIX_MAP   = 4'b1000;

    // Number of data bytes after the marker
    typedef enum logic [3:0] {
        NB_0 = 4'd0,
        NB_1 = 4'd1,
        NB_2 = 4'd2,
        NB_4 = 4'd4,
        NB_8 = 4'd8
    } t_nbytes;

    // One classified item: marker, data byte count, data left-aligned
    typedef struct packed {
        logic [7:0]  marker;
        t_nbytes     nbytes;
        logic [63:0] data;
    } t_cmd;

    localparam int QUEUE_DEPTH_DEF = 2;

endpackage

>>> design/mpe_front.sv
// Front end: accepts input words, picks marker and field size, registers the command.
// Depends on mpe_pkg.
module mpe_front
    import mpe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_op,
    input  logic [63:0] i_value,
    output logic        o_push,
    output t_cmd        o_cmd,
    input  logic        i_q_ready
);

    logic        r_valid, n_valid;
    t_cmd        r_cmd;
    t_cmd        w_cmd;
    logic        w_legal;
    logic [31:0] w_len;
    logic [63:0] v;

    assign v     = i_value;
    assign w_len = i_value[31:0];

    // Left-align the low bytes of the operand so the back end shifts from the top
    function automatic t_cmd mk(input logic [7:0] marker, input t_nbytes nb,
                                input logic [63:0] val);
        t_cmd c;
        c.marker = marker;
        c.nbytes = nb;
        unique case (nb)
            NB_0:    c.data = '0;
            NB_1:    c.data = {val[7:0], 56'd0};
            NB_2:    c.data = {val[15:0], 48'd0};
            NB_4:    c.data = {val[31:0], 32'd0};
            default: c.data = val;
        endcase
        return c;
    endfunction

    always_comb begin
        w_legal = 1'b1;
        w_cmd   = mk(MK_NIL, NB_0, '0);
        unique case (t_op'(i_op))
            OP_NIL:    w_cmd = mk(MK_NIL, NB_0, '0);
            OP_BOOL:   w_cmd = mk((|v) ? MK_TRUE : MK_FALSE, NB_0, '0);
            OP_UINT, OP_INT: begin
                if (!v[63] || t_op'(i_op) == OP_UINT) begin
                    priority if (v[63:7] == '0)  w_cmd = mk(v[7:0], NB_0, '0);
                    else if (v[63:8] == '0)      w_cmd = mk(MK_UINT8, NB_1, v);
                    else if (v[63:16] == '0)     w_cmd = mk(MK_UINT16, NB_2, v);
                    else if (v[63:32] == '0)     w_cmd = mk(MK_UINT32, NB_4, v);
                    else                         w_cmd = mk(MK_UINT64, NB_8, v);
                end else begin
                    priority if (&v[63:5])       w_cmd = mk(v[7:0], NB_0, '0);
                    else if (&v[63:7])           w_cmd = mk(MK_INT8, NB_1, v);
                    else if (&v[63:15])          w_cmd = mk(MK_INT16, NB_2, v);
                    else if (&v[63:31])          w_cmd = mk(MK_INT32, NB_4, v);
                    else                         w_cmd = mk(MK_INT64, NB_8, v);
                end
            end
            OP_DOUBLE: w_cmd = mk(MK_DOUBLE, NB_8, v);
            OP_BIN: begin
                priority if (w_len[31:8] == '0)  w_cmd = mk(MK_BIN8, NB_1, v);
                else if (w_len[31:16] == '0)     w_cmd = mk(MK_BIN16, NB_2, v);
                else                             w_cmd = mk(MK_BIN32, NB_4, v);
            end
            OP_STR: begin
                priority if (w_len[31:5] == '0)  w_cmd = mk({FIX_STR, w_len[4:0]}, NB_0, '0);
                else if (w_len[31:8] == '0)      w_cmd = mk(MK_STR8, NB_1, v);
                else if (w_len[31:16] == '0)     w_cmd = mk(MK_STR16, NB_2, v);
                else                             w_cmd = mk(MK_STR32, NB_4, v);
            end
            OP_ARRAY: begin
                priority if (w_len[31:4] == '0)  w_cmd = mk({FIX_ARRAY, w_len[3:0]}, NB_0, '0);
                else if (w_len[31:16] == '0)     w_cmd = mk(MK_ARR16, NB_2, v);
                else                             w_cmd = mk(MK_ARR32, NB_4, v);
            end
            OP_MAP: begin
                priority if (w_len[31:4] == '0)  w_cmd = mk({FIX_MAP, w_len[3:0]}, NB_0, '0);
                else if (w_len[31:16] == '0)     w_cmd = mk(MK_MAP16, NB_2, v);
                else                             w_cmd = mk(MK_MAP32, NB_4, v);
            end
            OP_PAYLOAD: w_cmd = mk(v[7:0], NB_0, '0);
            default:    w_legal = 1'b0;
        endcase
    end

    assign o_ready = !r_valid || i_q_ready;
    assign o_push  = r_valid && i_q_ready;
    assign o_cmd   = r_cmd;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid && w_legal;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (o_ready && i_valid && w_legal) begin
            r_cmd <= w_cmd;
        end
    end

endmodule

>>> design/mpe_queue.sv
// Command queue between front and back end; small register FIFO.
// Depends on mpe_pkg.
module mpe_queue
    import mpe_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_valid
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_count;

    assign o_ready = r_count < CW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == LAST) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == LAST) ? '0 : r_rp + 1'b1;
            end
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("queue count overflow");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0) else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_count < CW'(DEPTH)) else $error("push into full queue");

endmodule

>>> design/mpe_back.sv
// Back end: serializes one queued command into bytes through an output register.
// Depends on mpe_pkg.
module mpe_back
    import mpe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_q_cmd,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_byte
);

    logic        r_busy, n_busy;
    logic [3:0]  r_left, n_left;
    logic [63:0] r_data, n_data;
    logic        r_ovalid, n_ovalid;
    logic [7:0]  r_byte, n_byte;
    logic        r_last, n_last;
    logic        w_adv;

    assign w_adv = !r_ovalid || i_ready;
    assign o_pop = w_adv && !r_busy && i_q_valid;

    always_comb begin
        n_busy   = r_busy;
        n_left   = r_left;
        n_data   = r_data;
        n_ovalid = r_ovalid;
        n_byte   = r_byte;
        n_last   = r_last;
        if (w_adv) begin
            if (r_busy) begin
                n_ovalid = 1'b1;
                n_byte   = r_data[63:56];
                n_last   = (r_left == 4'd1);
                n_data   = {r_data[55:0], 8'd0};
                n_left   = r_left - 4'd1;
                n_busy   = (r_left != 4'd1);
            end else if (i_q_valid) begin
                n_ovalid = 1'b1;
                n_byte   = i_q_cmd.marker;
                n_last   = (i_q_cmd.nbytes == NB_0);
                n_data   = i_q_cmd.data;
                n_left   = i_q_cmd.nbytes;
                n_busy   = (i_q_cmd.nbytes != NB_0);
            end else begin
                n_ovalid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_left   <= '0;
        end else begin
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
            r_left   <= n_left;
        end
        r_data <= n_data;
        r_byte <= n_byte;
        r_last <= n_last;
    end

    assign o_valid     = r_ovalid;
    assign o_out_byte  = r_byte;
    assign o_last_byte = r_last;

    a_busy_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_left != '0) else $error("busy with no bytes left");
    a_busy_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_ovalid |-> !r_last) else $error("last byte flagged mid item");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_ovalid) else $error("popped command produced no byte");

endmodule

>>> design/msgpack_value_encoder_core.sv
// MessagePack value encoder top level: front end, command queue, byte serializer.
// Depends on mpe_pkg, mpe_front, mpe_queue, mpe_back.
//
// Each input word (op, value) is encoded as one MessagePack element and leaves as
// a stream of bytes on the output channel, marker first and multi-byte fields most
// significant byte first; o_last_byte flags the final byte of each word. Integers
// take their shortest form, double is sent as the raw IEEE bits, and bin, str,
// array and map produce only their header from the low 32 bits of value. A payload
// word passes its low byte through. Selector codes 10 to 15 are accepted and
// dropped without output. An element is 1 to 9 bytes long and leaves through the
// byte-wide output register of the serializer, which i_ready can stall; the marker
// of a queued word directly follows the last byte of the word before it. The front
// end classifies a word and registers the command, and a QUEUE_DEPTH-entry command
// queue (2 by default) decouples it from the serializer, so input is taken while the
// serializer is still busy. With nothing queued ahead, the first byte of a word is
// presented after passing the front-end register, the queue and the output register.
module msgpack_value_encoder_core
    import mpe_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_op,
    input  logic [63:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte
);

    // Front to queue
    logic w_push;
    t_cmd w_push_cmd;
    logic w_q_ready;
    // Queue to back
    logic w_pop;
    t_cmd w_pop_cmd;
    logic w_q_valid;

    // Classify and register the command
    mpe_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_op      (i_op),
        .i_value   (i_value),
        .o_push    (w_push),
        .o_cmd     (w_push_cmd),
        .i_q_ready (w_q_ready)
    );

    // Hold commands while the serializer drains earlier ones
    mpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_cmd   (w_pop_cmd),
        .o_valid (w_q_valid)
    );

    // Emit one byte per cycle through the output register unless i_ready stalls it
    mpe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_cmd     (w_pop_cmd),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

endmodule
